// ===== src/lsk_pkg.sv =====
// Shared types and constants for the keyed-remove LIFO stack.
// Used by lifo_stack_keyed_remove_unit and lsk_checker; no dependencies.
package lsk_pkg;

	// stack geometry
	localparam int DEPTH    = 64;
	localparam int KEY_BITS = 64;

	// port field widths
	localparam int OP_W      = 2;
	localparam int NAME_W    = 64;
	localparam int QTY_W     = 32;
	localparam int PRICE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int CNT_OUT_W = 7;

	// derived widths
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int REC_W = KEY_BITS + QTY_W + PRICE_W;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// one stored record
	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [QTY_W-1:0]    qty;
		logic [PRICE_W-1:0]  price;
	} rec_t;

endpackage

// ===== src/lsk_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lsk_ram #(
	parameter int WIDTH  = 8,
	parameter int WORDS  = 16,
	parameter int ADDR_W = $clog2(WORDS)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/lifo_stack_keyed_remove_unit.sv =====
// Push, clear and the empty/full cases pass through S_EXEC and S_FIN; pop adds S_POP.
// Remove: a search from the top entry down and then a shift of the entries above the hit,
// both one RAM read port access per cycle; a miss goes to S_FIN with no shift. in_ready is
// low from acceptance until the result is loaded into the output register, so a new
// transaction is taken only after the last one is through.
// Top level of the keyed-remove LIFO stack; uses lsk_pkg and lsk_ram. Reset empties it.
module lifo_stack_keyed_remove_unit
	import lsk_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [OP_W-1:0]            operation,
	input  logic [NAME_W-1:0]          name_key,
	input  logic signed [QTY_W-1:0]    quantity,
	input  logic [PRICE_W-1:0]         price_bits,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic [NAME_W-1:0]          out_name,
	output logic signed [QTY_W-1:0]    out_quantity,
	output logic [PRICE_W-1:0]         out_price,
	output logic [CNT_OUT_W-1:0]       entry_count
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SEARCH,
		S_SHIFT,
		S_FIN
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [QTY_W-1:0]    qty_q;
	logic [PRICE_W-1:0]  price_q;
	logic [CNT_W-1:0]    count_q;

	// search pointers
	logic [AW-1:0]       idx_q;
	logic                issue_q;
	logic                cmp_vld_q;
	logic [AW-1:0]       cmp_idx_q;

	// shift pointers
	logic [CNT_W-1:0]    src_q;
	logic                mv_vld_q;
	logic [AW-1:0]       mv_dst_q;

	// staged result and output register
	status_t             res_status_q;
	rec_t                res_rec_q;
	logic                out_valid_q;
	status_t             out_status_q;
	rec_t                out_rec_q;
	logic [CNT_W-1:0]    out_cnt_q;

	logic                in_acc;
	logic                full;
	logic                empty;
	logic                slot_free;
	logic                src_more;
	logic                key_hit;
	rec_t                rec_in;
	rec_t                rd_rec;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	rec_t                wr_rec;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [REC_W-1:0]    rd_data;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign slot_free = !out_valid_q || out_ready;
	assign src_more  = (src_q < count_q);
	assign rd_rec    = rec_t'(rd_data);
	assign key_hit   = (rd_rec.key == key_q);
	assign rec_in    = '{key: key_q, qty: qty_q, price: price_q};

	// RAM port steering by sequencer state
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_rec  = rec_in;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			S_EXEC: begin
				wr_en   = (op_q == OP_PUSH) && !full;
				rd_en   = (op_q == OP_POP) && !empty;
				rd_addr = AW'(count_q - CNT_W'(1));
			end
			S_SEARCH: begin
				rd_en   = issue_q;
				rd_addr = idx_q;
			end
			S_SHIFT: begin
				wr_en   = mv_vld_q;
				wr_addr = mv_dst_q;
				wr_rec  = rd_rec;
				rd_en   = src_more;
				rd_addr = src_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	lsk_ram #(
		.WIDTH (REC_W),
		.WORDS (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_rec),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer, stack count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_PUSH;
			key_q        <= '0;
			qty_q        <= '0;
			price_q      <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			issue_q      <= 1'b0;
			cmp_vld_q    <= 1'b0;
			cmp_idx_q    <= '0;
			src_q        <= '0;
			mv_vld_q     <= 1'b0;
			mv_dst_q     <= '0;
			res_status_q <= ST_OK;
			res_rec_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_rec_q    <= '0;
			out_cnt_q    <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q    <= op_t'(operation);
						key_q   <= name_key[KEY_BITS-1:0];
						qty_q   <= quantity;
						price_q <= price_bits;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_rec_q <= '0;
					case (op_q)
						OP_PUSH: begin
							if (full) begin
								res_status_q <= ST_FULL;
							end else begin
								count_q      <= count_q + CNT_W'(1);
								res_status_q <= ST_OK;
							end
							state_q <= S_FIN;
						end
						OP_POP: begin
							if (empty) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_POP;
							end
						end
						OP_REMOVE: begin
							if (empty) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_FIN;
							end else begin
								idx_q     <= AW'(count_q - CNT_W'(1));
								issue_q   <= 1'b1;
								cmp_vld_q <= 1'b0;
								state_q   <= S_SEARCH;
							end
						end
						OP_CLEAR: begin
							count_q      <= '0;
							res_status_q <= ST_OK;
							state_q      <= S_FIN;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_POP: begin
					res_rec_q    <= rd_rec;
					res_status_q <= ST_OK;
					count_q      <= count_q - CNT_W'(1);
					state_q      <= S_FIN;
				end
				S_SEARCH: begin
					// read issue runs one entry ahead of the compare
					if (issue_q) begin
						cmp_vld_q <= 1'b1;
						cmp_idx_q <= idx_q;
						if (idx_q == '0) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q - AW'(1);
						end
					end else begin
						cmp_vld_q <= 1'b0;
					end
					if (cmp_vld_q) begin
						if (key_hit) begin
							res_rec_q <= rd_rec;
							src_q     <= CNT_W'(cmp_idx_q) + CNT_W'(1);
							mv_vld_q  <= 1'b0;
							state_q   <= S_SHIFT;
						end else if (cmp_idx_q == '0) begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_FIN;
						end
					end
				end
				S_SHIFT: begin
					// move each entry above the hit down by one
					if (src_more) begin
						src_q    <= src_q + CNT_W'(1);
						mv_vld_q <= 1'b1;
						mv_dst_q <= AW'(src_q - CNT_W'(1));
					end else begin
						mv_vld_q <= 1'b0;
					end
					if (!src_more && !mv_vld_q) begin
						count_q      <= count_q - CNT_W'(1);
						res_status_q <= ST_OK;
						state_q      <= S_FIN;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_rec_q    <= res_rec_q;
						out_cnt_q    <= count_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// count reported after the operation; it is stable while a result waits
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign out_name     = NAME_W'(out_rec_q.key);
	assign out_quantity = out_rec_q.qty;
	assign out_price    = out_rec_q.price;
	assign entry_count  = CNT_OUT_W'(out_cnt_q);

endmodule

// ===== src/lsk_checker.sv =====
// Port-level checks for lifo_stack_keyed_remove_unit, bound to the top level.
// Uses lsk_pkg.
module lsk_port_checks
	import lsk_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [STATUS_W-1:0]     status,
	input logic [NAME_W-1:0]       out_name,
	input logic signed [QTY_W-1:0] out_quantity,
	input logic [PRICE_W-1:0]      out_price,
	input logic [CNT_OUT_W-1:0]    entry_count
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_name)
			&& $stable(entry_count))
		else $error("result changed while stalled");

	// full status only with a full stack
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> entry_count == CNT_OUT_W'(DEPTH))
		else $error("full status with stack not full");

	// empty status only with no entries
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> entry_count == '0)
		else $error("empty status with entries held");

	// failed operations return no record
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (out_name == '0) && (out_quantity == '0)
			&& (out_price == '0))
		else $error("record returned with error status");

endmodule

bind lifo_stack_keyed_remove_unit lsk_port_checks u_lsk_port_checks (.*);

// ===== dv/lsk_checker.sv =====
// Checker for the keyed-remove LIFO stack: watches both channels, keeps a
// shadow copy of the stack, predicts each result and compares it field by field.
// Depends on lsk_pkg for widths, opcodes and status codes.
`timescale 1ns / 1ps

module lsk_checker
	import lsk_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [OP_W-1:0]         operation,
	input  logic [NAME_W-1:0]       name_key,
	input  logic signed [QTY_W-1:0] quantity,
	input  logic [PRICE_W-1:0]      price_bits,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [STATUS_W-1:0]     status,
	input  logic [NAME_W-1:0]       out_name,
	input  logic signed [QTY_W-1:0] out_quantity,
	input  logic [PRICE_W-1:0]      out_price,
	input  logic [CNT_OUT_W-1:0]    entry_count,
	output int                      mismatch_count,
	output int                      results_due
);

	typedef struct {
		status_t                st;
		logic [NAME_W-1:0]      name;
		logic [QTY_W-1:0]       qty;
		logic [PRICE_W-1:0]     price;
		logic [CNT_OUT_W-1:0]   cnt;
	} stack_result_t;

	// shadow stack, index 0 is the bottom
	rec_t          shadow_mem [DEPTH];
	int            shadow_depth;
	stack_result_t pending_results [$];

	initial mismatch_count = 0;

	// apply one operation to the shadow stack and return the result it gives
	function automatic stack_result_t stack_apply(op_t op, logic [NAME_W-1:0] key_in,
			logic [QTY_W-1:0] qty_in, logic [PRICE_W-1:0] price_in);
		stack_result_t       r;
		logic [KEY_BITS-1:0] key;
		int                  hit;
		r.st    = ST_OK;
		r.name  = '0;
		r.qty   = '0;
		r.price = '0;
		key     = key_in[KEY_BITS-1:0];
		hit     = -1;
		case (op)
			OP_PUSH: begin
				if (shadow_depth >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					shadow_mem[shadow_depth].key   = key;
					shadow_mem[shadow_depth].qty   = qty_in;
					shadow_mem[shadow_depth].price = price_in;
					shadow_depth++;
				end
			end
			OP_POP: begin
				if (shadow_depth == 0) begin
					r.st = ST_EMPTY;
				end else begin
					shadow_depth--;
					r.name  = NAME_W'(shadow_mem[shadow_depth].key);
					r.qty   = shadow_mem[shadow_depth].qty;
					r.price = shadow_mem[shadow_depth].price;
				end
			end
			OP_REMOVE: begin
				if (shadow_depth == 0) begin
					r.st = ST_EMPTY;
				end else begin
					// topmost match wins
					for (int i = shadow_depth - 1; i >= 0; i--)
						if (hit < 0 && shadow_mem[i].key == key)
							hit = i;
					if (hit < 0) begin
						r.st = ST_NOT_FOUND;
					end else begin
						r.name  = NAME_W'(shadow_mem[hit].key);
						r.qty   = shadow_mem[hit].qty;
						r.price = shadow_mem[hit].price;
						// close the gap, order of the rest kept
						for (int j = hit; j < shadow_depth - 1; j++)
							shadow_mem[j] = shadow_mem[j + 1];
						shadow_depth--;
					end
				end
			end
			default: begin
				shadow_depth = 0;
			end
		endcase
		r.cnt = CNT_OUT_W'(shadow_depth);
		return r;
	endfunction

	task automatic check_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// result side first, then predict the newly accepted transaction
	always @(posedge clk or negedge arst_n) begin
		stack_result_t exp_r;
		if (!arst_n) begin
			shadow_depth = 0;
			pending_results.delete();
			results_due <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no transaction outstanding: status %0d", status);
					mismatch_count++;
				end else begin
					exp_r = pending_results.pop_front();
					check_field("status", 64'(exp_r.st), 64'(status));
					check_field("out_name", exp_r.name, out_name);
					check_field("out_quantity", 64'(exp_r.qty), 64'($unsigned(out_quantity)));
					check_field("out_price", 64'(exp_r.price), 64'(out_price));
					check_field("entry_count", 64'(exp_r.cnt), 64'(entry_count));
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(stack_apply(op_t'(operation), name_key,
					quantity, price_bits));
			results_due <= pending_results.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the keyed-remove LIFO stack testbench: clock, reset, stimulus and verdict.
// Instantiates lifo_stack_keyed_remove_unit and lsk_checker; uses lsk_pkg.
`timescale 1ns / 1ps

module testbench;
	import lsk_pkg::*;

	localparam int RAND_ITEMS  = 1860;
	localparam int FILL_PUSHES = DEPTH + 4;
	localparam int LONG_HOLD   = 400;
	localparam int POOL_N      = 12;
	localparam int TAIL_CYCLES = 2 * DEPTH + 8;
	localparam int CYCLE_LIMIT = 1_500_000;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    in_valid     = 1'b0;
	logic                    in_ready;
	logic [OP_W-1:0]         operation    = OP_PUSH;
	logic [NAME_W-1:0]       name_key     = '0;
	logic signed [QTY_W-1:0] quantity     = '0;
	logic [PRICE_W-1:0]      price_bits   = '0;
	logic                    out_valid;
	logic                    out_ready    = 1'b0;
	logic [STATUS_W-1:0]     status;
	logic [NAME_W-1:0]       out_name;
	logic signed [QTY_W-1:0] out_quantity;
	logic [PRICE_W-1:0]      out_price;
	logic [CNT_OUT_W-1:0]    entry_count;
	int                      mismatch_count;
	int                      results_due;

	logic              calm_tail     = 1'b0;
	logic              long_hold_req = 1'b0;
	int                gap_pct       = 10;
	int                cycle_cnt     = 0;
	logic [NAME_W-1:0] key_pool [POOL_N];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	lifo_stack_keyed_remove_unit u_top (.*);

	lsk_checker u_checker (.*);

	// mostly keys from a small pool so removes hit and duplicates occur
	function automatic logic [NAME_W-1:0] rand_key();
		if ($urandom_range(0, 99) < 75)
			return key_pool[$urandom_range(0, POOL_N - 1)];
		return {$urandom, $urandom};
	endfunction

	// 32-bit pattern with a bias toward the corners
	function automatic logic [31:0] rand_word();
		if ($urandom_range(0, 99) < 15) begin
			case ($urandom_range(0, 3))
				0:       return 32'h0000_0000;
				1:       return 32'hFFFF_FFFF;
				2:       return 32'h8000_0000;
				default: return 32'h7FFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	function automatic op_t pick_op(mix_t mix);
		int r;
		int push_lim;
		int pop_lim;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				push_lim = 70;
				pop_lim  = 80;
			end
			MIX_DRAIN: begin
				push_lim = 25;
				pop_lim  = 60;
			end
			default: begin
				push_lim = 48;
				pop_lim  = 72;
			end
		endcase
		if (r < push_lim)
			return OP_PUSH;
		if (r < pop_lim)
			return OP_POP;
		if (r < 99)
			return OP_REMOVE;
		return OP_CLEAR;
	endfunction

	// offer one transaction, hold it until accepted, then maybe go idle
	task automatic issue_op(op_t op, logic [NAME_W-1:0] key, logic [QTY_W-1:0] qty,
			logic [PRICE_W-1:0] price);
		in_valid   <= 1'b1;
		operation  <= op;
		name_key   <= key;
		quantity   <= qty;
		price_bits <= price;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15))
				@(posedge clk);
		end
	endtask

	// stop offering until every outstanding result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_due != 0);
	endtask

	// result side: random stall bursts, one long hold on request
	initial begin
		int stall_pct;
		int epoch;
		stall_pct = 0;
		epoch     = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (epoch == 0) begin
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 8;
					default: stall_pct = 35;
				endcase
				epoch = 200;
			end
			epoch--;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1)
					@(posedge clk);
			end else if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 14))
					@(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** lifo_stack_keyed_remove_unit: FAILED **");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic [NAME_W-1:0] k_dup;
		logic [NAME_W-1:0] k_other;
		logic [NAME_W-1:0] k_solo;
		logic [NAME_W-1:0] deep_key;
		mix_t              mix;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_N; i++)
			key_pool[i] = {$urandom, $urandom};
		k_dup    = {$urandom, $urandom};
		k_other  = {$urandom, $urandom};
		k_solo   = {$urandom, $urandom};
		deep_key = {$urandom, $urandom};
		mix      = MIX_EVEN;

		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-stack cases
		issue_op(OP_POP, rand_key(), rand_word(), rand_word());
		issue_op(OP_REMOVE, k_dup, rand_word(), rand_word());
		issue_op(OP_CLEAR, rand_key(), rand_word(), rand_word());
		// field extremes, a duplicated key
		issue_op(OP_PUSH, '0, 32'h8000_0000, 32'h0000_0000);
		issue_op(OP_PUSH, '1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue_op(OP_PUSH, k_dup, 32'hFFFF_FFFF, 32'h0000_0001);
		issue_op(OP_PUSH, k_dup, 32'h0000_0000, 32'h8000_0000);
		issue_op(OP_PUSH, k_other, 32'h0000_0001, 32'h7FFF_FFFF);
		// miss, topmost duplicate from the middle, bottom entry
		issue_op(OP_REMOVE, {$urandom, $urandom}, rand_word(), rand_word());
		issue_op(OP_REMOVE, k_dup, rand_word(), rand_word());
		issue_op(OP_REMOVE, '0, rand_word(), rand_word());
		issue_op(OP_POP, rand_key(), rand_word(), rand_word());
		issue_op(OP_POP, rand_key(), rand_word(), rand_word());
		issue_op(OP_POP, rand_key(), rand_word(), rand_word());
		issue_op(OP_POP, rand_key(), rand_word(), rand_word());
		// clear with content, then the top entry removed by key
		issue_op(OP_PUSH, k_other, rand_word(), rand_word());
		issue_op(OP_PUSH, k_dup, rand_word(), rand_word());
		issue_op(OP_CLEAR, rand_key(), rand_word(), rand_word());
		issue_op(OP_POP, rand_key(), rand_word(), rand_word());
		issue_op(OP_PUSH, k_solo, rand_word(), rand_word());
		issue_op(OP_REMOVE, k_solo, rand_word(), rand_word());
		issue_op(OP_REMOVE, k_solo, rand_word(), rand_word());
		wait_drained();

		// fill to capacity behind a long result-side hold, then hit full
		// and remove the bottom entry of a full stack
		issue_op(OP_CLEAR, rand_key(), rand_word(), rand_word());
		long_hold_req = 1'b1;
		issue_op(OP_PUSH, deep_key, rand_word(), rand_word());
		for (int i = 1; i < FILL_PUSHES; i++)
			issue_op(OP_PUSH, key_pool[i % POOL_N], rand_word(), rand_word());
		issue_op(OP_REMOVE, deep_key, rand_word(), rand_word());
		issue_op(OP_PUSH, rand_key(), rand_word(), rand_word());
		issue_op(OP_PUSH, rand_key(), rand_word(), rand_word());
		wait_drained();

		// random phases, each with its own op mix and idle rate
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 150 == 0) begin
				mix = mix_t'($urandom_range(0, 2));
				case ($urandom_range(0, 2))
					0:       gap_pct = 0;
					1:       gap_pct = 10;
					default: gap_pct = 40;
				endcase
			end
			if (n == RAND_ITEMS / 2)
				wait_drained();
			if (n == RAND_ITEMS * 9 / 10)
				calm_tail = 1'b1;
			issue_op(pick_op(mix), rand_key(), rand_word(), rand_word());
		end

		wait_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("** lifo_stack_keyed_remove_unit: PASSED **");
		else
			$display("** lifo_stack_keyed_remove_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lsk_pkg.sv
src/lsk_ram.sv
src/lifo_stack_keyed_remove_unit.sv
src/lsk_checker.sv
dv/lsk_checker.sv
dv/testbench.sv
